/* sv/plac_pkg.sv */
`timescale 1ns / 1ps

package plac_pkg;

    // defaults for the top level parameters
    localparam int FRAC_BITS_DEF   = 16;
    localparam int NUM_CLASSES_DEF = 16;

    // fixed-point constants in q24
    localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
    localparam logic [23:0] LN2_Q24   = 24'd11629080;
    localparam logic [25:0] ONE_Q24   = 26'h100_0000;

    // reciprocal pipeline: stages and quotient bits per stage
    localparam int DIV_STAGES = 5;
    localparam int DIV_STEPS  = 5;

    typedef enum logic [2:0] {
        MODE_SQUARED   = 3'd0,
        MODE_HINGE     = 3'd1,
        MODE_LOGISTIC  = 3'd2,
        MODE_WLOGISTIC = 3'd3,
        MODE_EXP       = 3'd4
    } loss_mode_t;

    typedef enum logic [1:0] {
        CFG_LOSS_MODE = 2'd0,
        CFG_PAIR_MODE = 2'd1,
        CFG_TOLERANCE = 2'd2
    } cfg_index_t;

    // everything one item carries down the pipeline
    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] t;
        logic [3:0]         cls;
        logic               hc;
        loss_mode_t         mode;
        logic               correct;
        logic               pos;
        logic               zneg;
        logic               zpos;
        logic [31:0]        az;
        logic [31:0]        w;
        logic [56:0]        prod;
        logic [63:0]        sq;
        logic signed [32:0] q;
        logic signed [32:0] h;
        logic [25:0]        base1;
        logic [25:0]        base2;
        logic [42:0]        dp1;
        logic [42:0]        dp2;
        logic signed [9:0]  e1;
        logic signed [9:0]  e2;
        logic [32:0]        expv;
        logic [24:0]        en;
        logic [25:0]        den;
        logic [24:0]        lbase;
        logic [42:0]        ldp;
        logic [48:0]        lp;
        logic [30:0]        spl;
        logic [25:0]        rem;
        logic [24:0]        quo;
        logic [24:0]        g;
        logic [62:0]        ml;
        logic [56:0]        mg;
        logic [30:0]        loss;
        logic signed [31:0] grad;
    } item_t;

    // 2^(i/8) in q24
    function automatic logic [25:0] pow2_tab(input logic [3:0] idx);
        logic [25:0] v;
        case (idx)
            4'd0: v = 26'd16777216;
            4'd1: v = 26'd18295684;
            4'd2: v = 26'd19951585;
            4'd3: v = 26'd21757357;
            4'd4: v = 26'd23726566;
            4'd5: v = 26'd25874004;
            4'd6: v = 26'd28215802;
            4'd7: v = 26'd30769550;
            4'd8: v = 26'd33554432;
            default: v = 26'd0;
        endcase
        return v;
    endfunction

    // log2(1 + i/8) in q24
    function automatic logic [24:0] log2_tab(input logic [3:0] idx);
        logic [24:0] v;
        case (idx)
            4'd0: v = 25'd0;
            4'd1: v = 25'd2850868;
            4'd2: v = 25'd5401057;
            4'd3: v = 25'd7707984;
            4'd4: v = 25'd9814042;
            4'd5: v = 25'd11751428;
            4'd6: v = 25'd13545168;
            4'd7: v = 25'd15215099;
            4'd8: v = 25'd16777216;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

endpackage

/* sv/pointwise_loss_accumulator_core.sv */
`timescale 1ns / 1ps

// Pointwise training loss core: takes one scored example (score, nonzero target,
// optional class) per clock and returns its loss, gradient and correct flag
// together with the running overall loss sum, correct count and frame count, all
// after this example. The path is a stalling pipeline: a new example is taken
// every cycle that the output side is not held, and each example passes through
// the exp/log interpolation stages and the five-stage reciprocal divider used for
// the sigmoid. m_ready low with a result waiting freezes the whole pipeline.
// Configuration must be written on the cfg port only while no example is in
// flight; the block itself does not enforce this. Totals and per-class counters
// clear at reset and saturate.
module pointwise_loss_accumulator_core #(
    parameter int NUM_CLASSES = plac_pkg::NUM_CLASSES_DEF,
    parameter int FRAC_BITS   = plac_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_score,
    input  logic signed [31:0] s_target_value,
    input  logic [3:0]         s_example_class,
    input  logic               s_has_class,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [30:0]        m_loss,
    output logic signed [31:0] m_gradient,
    output logic               m_is_correct,
    output logic [46:0]        m_total_loss_sum,
    output logic [31:0]        m_total_correct_count,
    output logic [31:0]        m_total_frame_count,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import plac_pkg::*;

    loss_mode_t  loss_mode_reg;
    logic        pair_mode_reg;
    logic [30:0] tolerance_reg;

    logic  advance;
    item_t front_item, div_item, back_item;
    logic  front_valid, div_valid, back_valid;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loss_mode_reg <= MODE_SQUARED;
            pair_mode_reg <= 1'b0;
            tolerance_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LOSS_MODE: loss_mode_reg <= loss_mode_t'(cfg_data[2:0]);
                CFG_PAIR_MODE: pair_mode_reg <= cfg_data[0];
                CFG_TOLERANCE: tolerance_reg <= cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // whole pipeline moves unless a result is held
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    plac_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .in_valid     (s_valid),
        .in_score     (s_score),
        .in_target    (s_target_value),
        .in_class     (s_example_class),
        .in_has_class (s_has_class),
        .loss_mode    (loss_mode_reg),
        .pair_mode    (pair_mode_reg),
        .tolerance    (tolerance_reg),
        .out_item     (front_item),
        .out_valid    (front_valid)
    );

    plac_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .out_item  (div_item),
        .out_valid (div_valid)
    );

    plac_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (div_valid),
        .in_item   (div_item),
        .out_item  (back_item),
        .out_valid (back_valid)
    );

    plac_stats #(
        .NUM_CLASSES(NUM_CLASSES)
    ) u_stats (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .advance               (advance),
        .in_valid              (back_valid),
        .in_item               (back_item),
        .m_valid               (m_valid),
        .m_loss                (m_loss),
        .m_gradient            (m_gradient),
        .m_is_correct          (m_is_correct),
        .m_total_loss_sum      (m_total_loss_sum),
        .m_total_correct_count (m_total_correct_count),
        .m_total_frame_count   (m_total_frame_count)
    );

endmodule

/* sv/plac_front.sv */
`timescale 1ns / 1ps

module plac_front #(
    parameter int FRAC_BITS = plac_pkg::FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic                 in_valid,
    input  logic signed [31:0]   in_score,
    input  logic signed [31:0]   in_target,
    input  logic [3:0]           in_class,
    input  logic                 in_has_class,
    input  plac_pkg::loss_mode_t loss_mode,
    input  logic                 pair_mode,
    input  logic [30:0]          tolerance,
    output plac_pkg::item_t      out_item,
    output logic                 out_valid
);
    import plac_pkg::*;

    localparam int SH24 = 24 - FRAC_BITS;
    localparam logic signed [33:0] ZLIM = 34'sd128 <<< FRAC_BITS;
    localparam logic [32:0] SPL_CAP = 33'((64'd126 * 64'(LN2_Q24)) >> SH24);

    item_t st0_reg, st1_reg, st2_reg, st3_reg, st4_reg, st5_reg, st6_reg;
    item_t st0_next, st1_next, st2_next, st3_next, st4_next, st5_next, st6_next;
    logic [6:0] v_reg;

    logic signed [33:0] sx, zf, zc, z24;
    logic signed [32:0] tt;
    logic [31:0]        m;
    logic signed [57:0] x1, x2;
    logic signed [33:0] y1, y2;
    logic [25:0]        diff1, diff2, mant1, mant2;
    logic signed [10:0] sh1, nsh1, r2;
    logic [24:0]        ldiff, l;
    logic [32:0]        rsum, rq;

    // input register
    always_comb begin
        st0_next = '0;
        st0_next.s = in_score;
        st0_next.t = in_target;
        st0_next.cls = in_class;
        st0_next.hc = in_has_class;
    end

    // sign, clamp, error terms, weight, correct flag, log2(e) product
    always_comb begin
        st1_next = st0_reg;
        st1_next.mode = loss_mode;
        st1_next.pos = st0_reg.t > 0;
        sx = 34'(st0_reg.s);
        zf = st1_next.pos ? -sx : sx;
        if (zf > ZLIM) begin
            zc = ZLIM;
        end else if (zf < -ZLIM) begin
            zc = -ZLIM;
        end else begin
            zc = zf;
        end
        z24 = zc <<< SH24;
        st1_next.zneg = zc < 0;
        st1_next.zpos = zc > 0;
        st1_next.az = (zc < 0) ? 32'(-z24) : 32'(z24);
        st1_next.prod = 57'(st1_next.az) * 57'(LOG2E_Q24);
        st1_next.q = 33'(st0_reg.s) - 33'(st0_reg.t);
        m = (st1_next.q < 0) ? 32'(-st1_next.q) : 32'(st1_next.q);
        st1_next.sq = 64'(m) * 64'(m);
        st1_next.h = st1_next.pos ? (33'(st0_reg.t) - 33'(st0_reg.s)) : st1_next.q;
        tt = 33'(st0_reg.t);
        st1_next.w = (tt < 0) ? 32'(-tt) : 32'(tt);
        if (pair_mode) begin
            st1_next.correct = (st0_reg.s > 0 && st0_reg.t > 0) ||
                               (st0_reg.s < 0 && st0_reg.t < 0);
        end else begin
            st1_next.correct = {1'b0, m} < {2'b00, tolerance};
        end
    end

    // exponent split and mantissa interpolation products
    always_comb begin
        st2_next = st1_reg;
        x2 = -$signed({1'b0, st1_reg.prod});
        x1 = st1_reg.zneg ? x2 : $signed({1'b0, st1_reg.prod});
        y1 = 34'(x1 >>> 24);
        y2 = 34'(x2 >>> 24);
        st2_next.e1 = 10'(y1 >>> 24);
        st2_next.e2 = 10'(y2 >>> 24);
        st2_next.base1 = pow2_tab({1'b0, y1[23:21]});
        st2_next.base2 = pow2_tab({1'b0, y2[23:21]});
        diff1 = pow2_tab({1'b0, y1[23:21]} + 4'd1) - st2_next.base1;
        diff2 = pow2_tab({1'b0, y2[23:21]} + 4'd1) - st2_next.base2;
        st2_next.dp1 = 43'(diff1[21:0]) * 43'(y1[20:0]);
        st2_next.dp2 = 43'(diff2[21:0]) * 43'(y2[20:0]);
    end

    // exp(z) in qf, exp(-|z|) in q24 and the sigmoid divisor
    always_comb begin
        st3_next = st2_reg;
        mant1 = st2_reg.base1 + 26'(st2_reg.dp1 >> 21);
        mant2 = st2_reg.base2 + 26'(st2_reg.dp2 >> 21);
        sh1 = 11'(st2_reg.e1) - 11'(SH24);
        nsh1 = -sh1;
        if (sh1 >= 11'sd8) begin
            st3_next.expv = 33'h1_0000_0000;
        end else if (sh1 >= 11'sd0) begin
            st3_next.expv = 33'(mant1) << sh1[2:0];
        end else if (nsh1 >= 11'sd26) begin
            st3_next.expv = '0;
        end else begin
            st3_next.expv = 33'(mant1 >> nsh1[4:0]);
        end
        r2 = -11'(st2_reg.e2);
        st3_next.en = (r2 >= 11'sd26) ? '0 : 25'(mant2 >> r2[4:0]);
        st3_next.den = ONE_Q24 + 26'(st3_next.en);
    end

    // log2(1 + e) interpolation product
    always_comb begin
        st4_next = st3_reg;
        ldiff = '0;
        if (st3_reg.en[24:21] >= 4'd8) begin
            st4_next.lbase = 25'h100_0000;
            st4_next.ldp = '0;
        end else begin
            st4_next.lbase = log2_tab(st3_reg.en[24:21]);
            ldiff = log2_tab(st3_reg.en[24:21] + 4'd1) - st4_next.lbase;
            st4_next.ldp = 43'(ldiff[21:0]) * 43'(st3_reg.en[20:0]);
        end
    end

    // scale by ln2
    always_comb begin
        st5_next = st4_reg;
        l = st4_reg.lbase + 25'(st4_reg.ldp >> 21);
        st5_next.lp = 49'(l) * 49'(LN2_Q24);
    end

    // softplus with its cap
    always_comb begin
        st6_next = st5_reg;
        rsum = 33'(st5_reg.zpos ? st5_reg.az : 32'd0) + 33'(st5_reg.lp >> 24);
        rq = rsum >> SH24;
        st6_next.spl = (rq < SPL_CAP) ? 31'(rq) : 31'(SPL_CAP);
    end

    // stage registers
    always_ff @(posedge aclk) begin
        if (advance) begin
            st0_reg <= st0_next;
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            st3_reg <= st3_next;
            st4_reg <= st4_next;
            st5_reg <= st5_next;
            st6_reg <= st6_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (advance) begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    assign out_item  = st6_reg;
    assign out_valid = v_reg[6];

endmodule

/* sv/plac_div.sv */
`timescale 1ns / 1ps

module plac_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            in_valid,
    input  plac_pkg::item_t in_item,
    output plac_pkg::item_t out_item,
    output logic            out_valid
);
    import plac_pkg::*;

    // restoring division of 2^48 by den, DIV_STEPS quotient bits per stage
    item_t div_reg [DIV_STAGES];
    item_t div_next [DIV_STAGES];
    logic [DIV_STAGES-1:0] v_reg;

    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                div_next[k] = in_item;
                div_next[k].rem = ONE_Q24;
                div_next[k].quo = '0;
            end else begin
                div_next[k] = div_reg[k-1];
            end
            for (int j = 0; j < DIV_STEPS; j++) begin
                if (div_next[k].rem >= div_next[k].den) begin
                    div_next[k].rem = div_next[k].rem - div_next[k].den;
                    div_next[k].quo = {div_next[k].quo[23:0], 1'b1};
                end else begin
                    div_next[k].quo = {div_next[k].quo[23:0], 1'b0};
                end
                div_next[k].rem = {div_next[k].rem[24:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (advance) begin
            v_reg <= {v_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    assign out_item  = div_reg[DIV_STAGES-1];
    assign out_valid = v_reg[DIV_STAGES-1];

endmodule

/* sv/plac_back.sv */
`timescale 1ns / 1ps

module plac_back #(
    parameter int FRAC_BITS = plac_pkg::FRAC_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            in_valid,
    input  plac_pkg::item_t in_item,
    output plac_pkg::item_t out_item,
    output logic            out_valid
);
    import plac_pkg::*;

    localparam int SH24 = 24 - FRAC_BITS;
    localparam logic signed [34:0] ONE_QF = 35'sd1 <<< FRAC_BITS;

    item_t b1_reg, b2_reg, b3_reg;
    item_t b1_next, b2_next, b3_next;
    logic [2:0] v_reg;

    logic [24:0]        s24;
    logic [63:0]        lraw;
    logic [32:0]        gmag;
    logic               use_mag;
    logic signed [34:0] graw;

    // sigmoid from the quotient, weighted loss product
    always_comb begin
        b1_next = in_item;
        s24 = in_item.zneg ? (25'h100_0000 - in_item.quo) : in_item.quo;
        b1_next.g = s24 >> SH24;
        b1_next.ml = 63'(in_item.spl) * 63'(in_item.w);
    end

    // weighted gradient product
    always_comb begin
        b2_next = b1_reg;
        b2_next.mg = 57'(b1_reg.g) * 57'(b1_reg.w);
    end

    // mode select and saturation
    always_comb begin
        b3_next = b2_reg;
        lraw = '0;
        gmag = '0;
        use_mag = 1'b0;
        graw = '0;
        case (b2_reg.mode)
            MODE_SQUARED: begin
                lraw = b2_reg.sq >> (FRAC_BITS + 1);
                graw = 35'(b2_reg.q);
            end
            MODE_HINGE: begin
                if (b2_reg.h > 0) begin
                    lraw = 64'(b2_reg.h[31:0]);
                    graw = b2_reg.pos ? -ONE_QF : ONE_QF;
                end
            end
            MODE_LOGISTIC: begin
                lraw = 64'(b2_reg.spl);
                gmag = 33'(b2_reg.g);
                use_mag = 1'b1;
            end
            MODE_WLOGISTIC: begin
                lraw = 64'(b2_reg.ml >> FRAC_BITS);
                gmag = 33'(b2_reg.mg >> FRAC_BITS);
                use_mag = 1'b1;
            end
            MODE_EXP: begin
                lraw = 64'(b2_reg.expv);
                gmag = b2_reg.expv;
                use_mag = 1'b1;
            end
            default: begin
                lraw = '0;
            end
        endcase
        if (use_mag) begin
            graw = b2_reg.pos ? -$signed({2'b00, gmag}) : $signed({2'b00, gmag});
        end
        b3_next.loss = (lraw > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : lraw[30:0];
        if (graw > 35'sh0_7FFF_FFFF) begin
            b3_next.grad = 32'sh7FFF_FFFF;
        end else if (graw < -35'sh0_8000_0000) begin
            b3_next.grad = 32'sh8000_0000;
        end else begin
            b3_next.grad = graw[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            b1_reg <= b1_next;
            b2_reg <= b2_next;
            b3_reg <= b3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (advance) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    assign out_item  = b3_reg;
    assign out_valid = v_reg[2];

endmodule

/* sv/plac_stats.sv */
`timescale 1ns / 1ps

module plac_stats #(
    parameter int NUM_CLASSES = plac_pkg::NUM_CLASSES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               in_valid,
    input  plac_pkg::item_t    in_item,
    output logic               m_valid,
    output logic [30:0]        m_loss,
    output logic signed [31:0] m_gradient,
    output logic               m_is_correct,
    output logic [46:0]        m_total_loss_sum,
    output logic [31:0]        m_total_correct_count,
    output logic [31:0]        m_total_frame_count
);
    import plac_pkg::*;

    // only sixteen classes can be addressed by the class field
    localparam int CLS_DEPTH = (NUM_CLASSES < 16) ? NUM_CLASSES : 16;
    localparam int CIDX_W = (CLS_DEPTH > 1) ? $clog2(CLS_DEPTH) : 1;
    localparam logic [46:0] SUM_MAX = '1;
    localparam logic [31:0] CNT_MAX = '1;

    logic [31:0] all_frames_reg, all_frames_next;
    logic [31:0] all_correct_reg, all_correct_next;
    logic [46:0] all_loss_sum_reg, all_loss_sum_next;
    logic [31:0] class_frames_reg [CLS_DEPTH];
    logic [31:0] class_correct_reg [CLS_DEPTH];
    logic [46:0] class_loss_sum_reg [CLS_DEPTH];
    logic [47:0] sum_wide, csum_wide;
    logic        fire, cls_hit;
    logic [CIDX_W-1:0] ci;

    logic               m_valid_reg;
    logic [30:0]        m_loss_reg;
    logic signed [31:0] m_gradient_reg;
    logic               m_is_correct_reg;

    assign fire    = in_valid && advance;
    assign cls_hit = in_item.hc && (int'(in_item.cls) < NUM_CLASSES);
    assign ci      = in_item.cls[CIDX_W-1:0];

    // saturating totals
    always_comb begin
        sum_wide = {1'b0, all_loss_sum_reg} + 48'(in_item.loss);
        all_loss_sum_next = (sum_wide > 48'(SUM_MAX)) ? SUM_MAX : sum_wide[46:0];
        all_frames_next = (all_frames_reg == CNT_MAX) ? CNT_MAX : all_frames_reg + 32'd1;
        all_correct_next = all_correct_reg;
        if (in_item.correct && all_correct_reg != CNT_MAX) begin
            all_correct_next = all_correct_reg + 32'd1;
        end
        csum_wide = {1'b0, class_loss_sum_reg[ci]} + 48'(in_item.loss);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            all_frames_reg   <= '0;
            all_correct_reg  <= '0;
            all_loss_sum_reg <= '0;
            for (int i = 0; i < CLS_DEPTH; i++) begin
                class_frames_reg[i]   <= '0;
                class_correct_reg[i]  <= '0;
                class_loss_sum_reg[i] <= '0;
            end
        end else if (fire) begin
            all_frames_reg   <= all_frames_next;
            all_correct_reg  <= all_correct_next;
            all_loss_sum_reg <= all_loss_sum_next;
            // per-class update of the one selected entry
            if (cls_hit) begin
                if (class_frames_reg[ci] != CNT_MAX) begin
                    class_frames_reg[ci] <= class_frames_reg[ci] + 32'd1;
                end
                if (in_item.correct && class_correct_reg[ci] != CNT_MAX) begin
                    class_correct_reg[ci] <= class_correct_reg[ci] + 32'd1;
                end
                class_loss_sum_reg[ci] <= (csum_wide > 48'(SUM_MAX)) ? SUM_MAX
                                                                     : csum_wide[46:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_loss_reg       <= in_item.loss;
            m_gradient_reg   <= in_item.grad;
            m_is_correct_reg <= in_item.correct;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_loss                = m_loss_reg;
    assign m_gradient            = m_gradient_reg;
    assign m_is_correct          = m_is_correct_reg;
    assign m_total_loss_sum      = all_loss_sum_reg;
    assign m_total_correct_count = all_correct_reg;
    assign m_total_frame_count   = all_frames_reg;

`ifndef SYNTHESIS
    a_correct_le_frames: assert property (@(posedge aclk) disable iff (!aresetn)
        all_correct_reg <= all_frames_reg)
        else $error("correct count above frame count");

    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid_reg)
        else $error("accepted item produced no result");

    a_frame_step: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && all_frames_reg != CNT_MAX |=> all_frames_reg == $past(all_frames_reg) + 32'd1)
        else $error("frame count did not step");

    a_sum_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(all_loss_sum_reg) && $stable(all_frames_reg))
        else $error("totals changed without an item");
`endif

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
    import plac_pkg::*;

    localparam longint ZLIM       = 64'sd128 <<< 16;
    localparam longint LOG2E      = 64'sd24204406;
    localparam longint LN2        = 64'sd11629080;
    localparam longint LOSS_MAX   = 64'h7FFF_FFFF;
    localparam longint SUM_MAX    = 64'h7FFF_FFFF_FFFF;
    localparam longint CNT_MAX    = 64'hFFFF_FFFF;
    localparam longint GRAD_MAX   = 64'sd2147483647;
    localparam longint GRAD_MIN   = -64'sd2147483648;
    localparam int     DRAIN      = 24;
    localparam int     CYCLE_CAP  = 600000;
    localparam int     RAND_ITEMS = 93;

    // codes that the package does not name
    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam longint POW2_Q24 [0:8] = '{16777216, 18295684, 19951585, 21757357,
        23726566, 25874004, 28215802, 30769550, 33554432};
    localparam longint LOG2P_Q24 [0:8] = '{0, 2850868, 5401057, 7707984, 9814042,
        11751428, 13545168, 15215099, 16777216};

    typedef struct {
        logic [30:0]        loss;
        logic signed [31:0] grad;
        logic               ok;
        logic [46:0]        lsum;
        logic [31:0]        ccnt;
        logic [31:0]        fcnt;
    } loss_result_t;

    class loss_scoreboard;
        logic [2:0]     mode;
        logic           pair;
        longint         tol;
        longint         cls_frames [16];
        longint         cls_correct [16];
        longint         cls_lsum [16];
        longint         frames, correct, lsum;
        loss_result_t   pending_q [$];
        int             errors;

        function new();
            mode = 0; pair = 0; tol = 0;
            frames = 0; correct = 0; lsum = 0; errors = 0;
            foreach (cls_frames[i]) begin
                cls_frames[i] = 0; cls_correct[i] = 0; cls_lsum[i] = 0;
            end
        endfunction

        function void configure(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_LOSS_MODE: mode = data[2:0];
                CFG_PAIR_MODE: pair = data[0];
                CFG_TOLERANCE: tol = longint'(data[30:0]);
                default: ;
            endcase
        endfunction

        function longint sat_add(longint a, longint b, longint lim);
            return (b >= lim - a) ? lim : a + b;
        endfunction

        function longint clamp_q24(longint z);
            if (z > ZLIM) z = ZLIM;
            if (z < -ZLIM) z = -ZLIM;
            return z * 256;
        endfunction

        // 2^(y/2^24) as a q24 mantissa in [1,2) and an exponent
        function longint pow2_mant(longint y, output longint n);
            longint f, idx, fr;
            n = y >>> 24;
            f = y & 64'hFF_FFFF;
            idx = f >> 21;
            fr = f & 64'h1F_FFFF;
            return POW2_Q24[idx] + (((POW2_Q24[idx+1] - POW2_Q24[idx]) * fr) >>> 21);
        endfunction

        function longint exp_neg_q24(longint a);
            longint n, v;
            v = pow2_mant((-a * LOG2E) >>> 24, n);
            if (-n >= 63) return 0;
            return v >> (-n);
        endfunction

        function longint exp_fix(longint z);
            longint n, v, sh;
            v = pow2_mant((clamp_q24(z) * LOG2E) >>> 24, n);
            sh = n - 8;
            if (sh >= 8) return 64'd1 << 32;
            if (sh >= 0) return v << sh;
            if (-sh >= 63) return 0;
            return v >> (-sh);
        endfunction

        function longint sigmoid_fix(longint z);
            longint z24;
            longint unsigned e, hi, s;
            z24 = clamp_q24(z);
            e = exp_neg_q24(z24 < 0 ? -z24 : z24);
            hi = (64'd1 << 48) / ((64'd1 << 24) + e);
            s = (z24 >= 0) ? hi : (64'd1 << 24) - hi;
            return longint'(s >> 8);
        endfunction

        function longint softplus_fix(longint z);
            longint z24, e, idx, l, fr, r, cap;
            z24 = clamp_q24(z);
            e = exp_neg_q24(z24 < 0 ? -z24 : z24);
            idx = e >> 21;
            if (idx >= 8) begin
                l = LOG2P_Q24[8];
            end else begin
                fr = e & 64'h1F_FFFF;
                l = LOG2P_Q24[idx] + (((LOG2P_Q24[idx+1] - LOG2P_Q24[idx]) * fr) >>> 21);
            end
            r = ((z24 > 0 ? z24 : 0) + ((l * LN2) >>> 24)) >> 8;
            cap = (126 * LN2) >> 8;
            return (r < cap) ? r : cap;
        endfunction

        // work out the result of one accepted item
        function void note_item(logic signed [31:0] score, logic signed [31:0] tgt,
                                logic [3:0] cls, logic hc);
            longint s, t, z, q, h, g, w, d, loss, grad;
            longint unsigned m;
            logic pos, ok;
            loss_result_t r;
            s = score; t = tgt;
            pos = t > 0;
            z = pos ? -s : s;
            loss = 0; grad = 0;
            case (mode)
                MODE_SQUARED: begin
                    q = s - t;
                    m = (q < 0) ? -q : q;
                    loss = longint'((m * m) >> 17);
                    grad = q;
                end
                MODE_HINGE: begin
                    h = pos ? t - s : s - t;
                    if (h > 0) begin
                        loss = h;
                        grad = pos ? -65536 : 65536;
                    end
                end
                MODE_LOGISTIC, MODE_WLOGISTIC: begin
                    g = sigmoid_fix(z);
                    loss = softplus_fix(z);
                    if (mode == MODE_WLOGISTIC) begin
                        w = (t < 0) ? -t : t;
                        loss = (loss * w) >> 16;
                        g = (g * w) >> 16;
                    end
                    grad = pos ? -g : g;
                end
                MODE_EXP: begin
                    loss = exp_fix(z);
                    grad = pos ? -loss : loss;
                end
                default: ;
            endcase
            if (loss > LOSS_MAX) loss = LOSS_MAX;
            if (grad > GRAD_MAX) grad = GRAD_MAX;
            if (grad < GRAD_MIN) grad = GRAD_MIN;
            if (pair) begin
                ok = (s > 0 && t > 0) || (s < 0 && t < 0);
            end else begin
                d = s - t;
                ok = ((d < 0) ? -d : d) < tol;
            end
            frames = sat_add(frames, 1, CNT_MAX);
            if (ok) correct = sat_add(correct, 1, CNT_MAX);
            lsum = sat_add(lsum, loss, SUM_MAX);
            if (hc) begin
                cls_frames[cls] = sat_add(cls_frames[cls], 1, CNT_MAX);
                if (ok) cls_correct[cls] = sat_add(cls_correct[cls], 1, CNT_MAX);
                cls_lsum[cls] = sat_add(cls_lsum[cls], loss, SUM_MAX);
            end
            r.loss = loss[30:0];
            r.grad = grad[31:0];
            r.ok = ok;
            r.lsum = lsum[46:0];
            r.ccnt = correct[31:0];
            r.fcnt = frames[31:0];
            pending_q = {pending_q, r};
        endfunction

        function void check_result(loss_result_t a);
            loss_result_t e;
            if (pending_q.size() == 0) begin
                $display("%0t unexpected result loss %0d", $time, a.loss);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (a.loss !== e.loss) begin
                $display("%0t loss expected %0d actual %0d", $time, e.loss, a.loss);
                errors++;
            end
            if (a.grad !== e.grad) begin
                $display("%0t gradient expected %0d actual %0d", $time, e.grad, a.grad);
                errors++;
            end
            if (a.ok !== e.ok) begin
                $display("%0t is_correct expected %0d actual %0d", $time, e.ok, a.ok);
                errors++;
            end
            if (a.lsum !== e.lsum) begin
                $display("%0t loss sum expected %0d actual %0d", $time, e.lsum, a.lsum);
                errors++;
            end
            if (a.ccnt !== e.ccnt) begin
                $display("%0t correct count expected %0d actual %0d", $time, e.ccnt, a.ccnt);
                errors++;
            end
            if (a.fcnt !== e.fcnt) begin
                $display("%0t frame count expected %0d actual %0d", $time, e.fcnt, a.fcnt);
                errors++;
            end
        endfunction
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic signed [31:0] s_score = 0;
    logic signed [31:0] s_target_value = 0;
    logic [3:0]         s_example_class = 0;
    logic               s_has_class = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [30:0]        m_loss;
    logic signed [31:0] m_gradient;
    logic               m_is_correct;
    logic [46:0]        m_total_loss_sum;
    logic [31:0]        m_total_correct_count;
    logic [31:0]        m_total_frame_count;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = 0;
    logic [31:0]        cfg_data = 0;

    loss_scoreboard sb = new();
    bit  tx_calm = 0;
    bit  rx_calm = 0;
    int  rx_hold = 0;
    int  cycles = 0;

    pointwise_loss_accumulator_core DUT (.*);

    always #1 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic int gap_len(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random back-pressure
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 0;
        end else begin
            m_ready <= 1;
            rx_hold <= gap_len(rx_calm);
        end
    end

    // result checking
    always @(posedge aclk) begin
        loss_result_t a;
        if (aresetn && m_valid && m_ready) begin
            a.loss = m_loss;
            a.grad = m_gradient;
            a.ok = m_is_correct;
            a.lsum = m_total_loss_sum;
            a.ccnt = m_total_correct_count;
            a.fcnt = m_total_frame_count;
            sb.check_result(a);
        end
    end

    task automatic send_item(logic signed [31:0] sc, logic signed [31:0] tg,
                             logic [3:0] cls, logic hc);
        int gap;
        s_valid <= 1;
        s_score <= sc;
        s_target_value <= tg;
        s_example_class <= cls;
        s_has_class <= hc;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(sc, tg, cls, hc);
        gap = gap_len(tx_calm);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.configure(idx, data);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic send_random();
        logic signed [31:0] sc, tg;
        case ($urandom_range(0, 5))
            0: tg = $urandom();
            1: tg = $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
            2: tg = $urandom_range(0, 1) ? 32'sh1_0000 : -32'sh1_0000;
            3: tg = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: tg = $signed($urandom_range(0, 32'h400_0000)) - 32'sh200_0000;
        endcase
        if ($urandom_range(0, 40) == 0) tg = 0;
        case ($urandom_range(0, 5))
            0: sc = $urandom();
            1: sc = tg + $signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000;
            2: sc = $signed($urandom_range(0, 32'h120_0000)) - 32'sh90_0000;
            3: sc = $signed($urandom_range(0, 2000)) - 1000;
            4: sc = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: sc = $signed($urandom_range(0, 32'h1000_0000)) - 32'sh800_0000;
        endcase
        if ($urandom_range(0, 40) == 0) sc = 0;
        send_item(sc, tg, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endtask

    // one phase: drain, settings, two extreme items, then random traffic
    task automatic run_phase(logic [2:0] mode, logic pair, logic [31:0] tol);
        drain();
        write_reg(CFG_LOSS_MODE, {29'($urandom()), mode});
        write_reg(CFG_PAIR_MODE, {31'($urandom()), pair});
        write_reg(CFG_TOLERANCE, tol);
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 4'd15, 1'b1);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 4'd0, 1'b0);
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == RAND_ITEMS / 2 && $urandom_range(0, 1))
                while (sb.pending_q.size() != 0) begin
                    s_valid <= 0;
                    @(posedge aclk);
                end
            send_random();
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: extremes, zero target, signs, near tolerance, every class flag
        write_reg(CFG_TOLERANCE, 32'h0001_0000);
        send_item(0, 32'sh1_0000, 4'd3, 1'b1);
        send_item(32'sh1_0000, 32'sh1_0000, 4'd15, 1'b1);
        send_item(32'sh0_FFFF, 0, 4'd7, 1'b1);
        send_item(32'sh1_0000, 0, 4'd7, 1'b0);
        send_item(-32'sh0_8000, -32'sh1_0000, 4'd0, 1'b1);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 4'd15, 1'b1);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 4'd10, 1'b0);
        send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 4'd5, 1'b1);
        send_item(32'sh8000_0000, 32'sh8000_0000, 4'd5, 1'b1);
        send_item(-1, 1, 4'd1, 1'b1);
        drain();
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
        run_phase(MODE_HINGE, 1'b1, 32'h0);
        run_phase(MODE_LOGISTIC, 1'b0, 32'h0004_0000);
        run_phase(MODE_WLOGISTIC, 1'b1, 32'hFFFF_FFFF);
        run_phase(MODE_EXP, 1'b0, 32'h0000_8000);
        run_phase(MODE_SQUARED, 1'b0, 32'h7FFF_FFFF);
        run_phase(MODE_SPARE_LO, 1'b1, 32'h0002_0000);
        run_phase(MODE_SPARE_HI, 1'b0, 32'h0001_0000);
        run_phase(MODE_LOGISTIC, 1'b1, 32'h0);
        run_phase(MODE_EXP, 1'b1, 32'h0010_0000);
        run_phase(MODE_WLOGISTIC, 1'b0, 32'h0003_0000);
        drain();
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/plac_pkg.sv
sv/plac_front.sv
sv/plac_div.sv
sv/plac_back.sv
sv/plac_stats.sv
sv/pointwise_loss_accumulator_core.sv
sim/tb.sv
